// ===== sv/blo_pkg.sv =====
// shared types and constants for the bounded ordered list
`timescale 1ns / 1ps
package blo_pkg;

    localparam int DATA_W    = 32;
    localparam int ACT_W     = 2;
    localparam int POS_W     = 5;
    localparam int STAT_W    = 2;
    localparam int FIDX_W    = 4;
    localparam int LEN_W     = 5;
    localparam int DEPTH_DEF = 16;
    // match bits examined per scan cycle
    localparam int SCAN_W    = 8;

    localparam logic [ACT_W-1:0] ACT_FIND   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;
    // spare code, answered as a bad request
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND    = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_POSITION = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL         = 2'd3;

    typedef struct packed {
        logic                     ins_en;
        logic                     del_en;
        logic                     cmp_en;
        logic                     scan_shift;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ===== sv/blo_cell.sv =====
// one list cell: holds one entry and one match bit
`timescale 1ns / 1ps
module blo_cell #(
    parameter int DEPTH = 16,
    parameter int IDX   = 0,
    parameter int CW    = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  blo_pkg::cell_ctrl_t              ctrl,
    input  logic [CW-1:0]                    count,
    input  logic signed [blo_pkg::DATA_W-1:0] left_entry,
    input  logic signed [blo_pkg::DATA_W-1:0] right_entry,
    input  logic                             match_in,
    output logic signed [blo_pkg::DATA_W-1:0] entry,
    output logic                             match
);
    import blo_pkg::*;

    localparam int IW = ($clog2(DEPTH) > POS_W) ? $clog2(DEPTH) : POS_W;

    logic signed [DATA_W-1:0] entry_reg, entry_next;
    logic                     match_reg, match_next;
    logic [IW-1:0]            pos_ext;
    logic                     occupied;

    assign pos_ext  = IW'(ctrl.pos);
    assign occupied = CW'(IDX) < count;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en)
        begin
            if (IW'(IDX) == pos_ext)
                entry_next = ctrl.value;
            else if (IW'(IDX) > pos_ext)
                entry_next = left_entry;
        end
        else if (ctrl.del_en)
        begin
            if (IW'(IDX) >= pos_ext)
                entry_next = right_entry;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.cmp_en)
            match_next = occupied && (entry_reg == ctrl.value);
        else if (ctrl.scan_shift)
            match_next = match_in;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else
            match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

// ===== sv/bounded_ordered_list_top.sv =====
// bounded ordered list: a row of entry cells with find, insert and delete
//
// usage: drive action, value and position with start high; the transaction is
// taken at a rising edge where start is high and busy is low.
// insert and delete shift the entries at or after the position by one cell
// at once: on insert the cell at the position loads the value and each later
// cell its left neighbor, on delete each such cell loads its right neighbor.
// their result (and that of an unused action code) appears on done in the cycle
// after the transaction is taken; busy stays low. find compares all cells at
// once in the accepting cycle, then scans the match bits eight per cycle as they
// shift down the row; busy is high while the scan runs.
// each result (status, found_index, length) is shown for exactly one cycle
// with done high; the receiver cannot stall, so nothing is held back.
// reset empties the list (length zero); entry contents are not cleared and
// only positions below the length are ever read.
`timescale 1ns / 1ps
module bounded_ordered_list_top #(
    parameter int DEPTH = blo_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [blo_pkg::ACT_W-1:0]         action,
    input  logic signed [blo_pkg::DATA_W-1:0] value,
    input  logic [blo_pkg::POS_W-1:0]         position,
    output logic                              done,
    output logic [blo_pkg::STAT_W-1:0]        status,
    output logic [blo_pkg::FIDX_W-1:0]        found_index,
    output logic [blo_pkg::LEN_W-1:0]         length
);
    import blo_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int BW   = $clog2(DEPTH + SCAN_W + 1);
    localparam int PW   = $clog2(SCAN_W);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                    state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [BW-1:0]             base_reg, base_next;
    logic                      done_reg, done_next;
    logic [STAT_W-1:0]         status_reg, status_next;
    logic [FIDX_W-1:0]         found_reg, found_next;
    logic [LEN_W-1:0]          length_reg, length_next;

    cell_ctrl_t                ctrl;
    logic                      accept;
    logic [CMPW-1:0]           pos_ext, cnt_ext;
    logic                      full;
    logic                      ins_bad, del_bad;
    logic signed [DATA_W-1:0]  entry_w [DEPTH];
    logic [DEPTH-1:0]          match_w;
    logic [DEPTH-1:0]          match_in_w;
    logic [SCAN_W-1:0]         scan_bits;
    logic                      hit, last;
    logic [PW-1:0]             hit_idx;
    logic [BW-1:0]             base_step, hit_pos;

    assign busy    = (state_reg == S_SCAN);
    assign accept  = start && !busy;
    assign pos_ext = CMPW'(position);
    assign cnt_ext = CMPW'(count_reg);
    assign full    = (count_reg == CW'(DEPTH));
    assign ins_bad = pos_ext > cnt_ext;
    assign del_bad = pos_ext >= cnt_ext;

    always_comb
    begin
        ctrl.ins_en     = accept && (action == ACT_INSERT) && !ins_bad && !full;
        ctrl.del_en     = accept && (action == ACT_DELETE) && !del_bad;
        ctrl.cmp_en     = accept && (action == ACT_FIND);
        ctrl.scan_shift = busy && !hit && !last;
        ctrl.pos        = position;
        ctrl.value      = value;
    end

    // row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_e, right_e;
        if (i == 0)
        begin : g_first
            assign left_e = value;
        end
        else
        begin : g_left
            assign left_e = entry_w[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_e = entry_w[i];
        end
        else
        begin : g_right
            assign right_e = entry_w[i+1];
        end
        // match bits move down by one scan group per cycle while a scan goes on
        if (i + SCAN_W < DEPTH)
        begin : g_min
            assign match_in_w[i] = match_w[i+SCAN_W];
        end
        else
        begin : g_mzero
            assign match_in_w[i] = 1'b0;
        end

        blo_cell #(
            .DEPTH (DEPTH),
            .IDX   (i),
            .CW    (CW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .count       (count_reg),
            .left_entry  (left_e),
            .right_entry (right_e),
            .match_in    (match_in_w[i]),
            .entry       (entry_w[i]),
            .match       (match_w[i])
        );
    end

    for (genvar k = 0; k < SCAN_W; k++)
    begin : g_scan
        if (k < DEPTH)
        begin : g_bit
            assign scan_bits[k] = match_w[k];
        end
        else
        begin : g_pad
            assign scan_bits[k] = 1'b0;
        end
    end

    // lowest set bit of the group under the scan window
    always_comb
    begin
        hit_idx = '0;
        for (int k = SCAN_W - 1; k >= 0; k--)
        begin
            if (scan_bits[k])
                hit_idx = PW'(k);
        end
    end

    assign hit       = |scan_bits;
    assign base_step = base_reg + BW'(SCAN_W);
    assign hit_pos   = base_reg + BW'(hit_idx);
    assign last      = base_step >= BW'(count_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        base_next   = base_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        length_next = length_reg;

        if (ctrl.ins_en)
            count_next = count_reg + CW'(1);
        else if (ctrl.del_en)
            count_next = count_reg - CW'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_FIND)
                    begin
                        state_next = S_SCAN;
                        base_next  = '0;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        found_next  = '0;
                        length_next = LEN_W'(count_next);
                        if (action == ACT_INSERT)
                            status_next = ins_bad ? ST_BAD_POSITION :
                                          (full ? ST_FULL : ST_OK);
                        else if (action == ACT_DELETE)
                            status_next = del_bad ? ST_BAD_POSITION : ST_OK;
                        else
                            status_next = ST_BAD_POSITION;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit || last)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = hit ? ST_OK : ST_NOT_FOUND;
                    found_next  = hit ? hit_pos[FIDX_W-1:0] : '0;
                    length_next = LEN_W'(count_reg);
                end
                else
                begin
                    base_next = base_step;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            base_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            base_reg  <= base_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        found_reg  <= found_next;
        length_reg <= length_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign found_index = found_reg;
    assign length      = length_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("list length above depth");

    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (action != ACT_FIND) |=> done && !busy)
        else $error("insert or delete result not produced next cycle");

    a_find_scans: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (action == ACT_FIND) |=> busy && !done)
        else $error("find did not enter scan");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_FULL) |-> (count_reg == CW'(DEPTH)))
        else $error("full reported on a list that is not full");

endmodule

// ===== tb/sv/bounded_ordered_list_top_tb.sv =====
// testbench for the bounded ordered list: directed and random find/insert/delete against a list predictor
`timescale 1ns / 1ps
module bounded_ordered_list_top_tb;
    import blo_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEF;
    localparam int RANDOM_OPS  = 1800;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [ACT_W-1:0]         act;
        logic signed [DATA_W-1:0] val;
        logic [POS_W-1:0]         pos;
    } list_op_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [FIDX_W-1:0] found_index;
        logic [LEN_W-1:0]  length;
    } list_reply_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [ACT_W-1:0]         action = ACT_FIND;
    logic signed [DATA_W-1:0] value = '0;
    logic [POS_W-1:0]         position = '0;
    logic                     done;
    logic [STAT_W-1:0]        status;
    logic [FIDX_W-1:0]        found_index;
    logic [LEN_W-1:0]         length;

    // predictor state: words held in positional order and their count
    logic signed [DATA_W-1:0] list_words [LIST_DEPTH];
    int                       list_len = 0;

    list_op_t    op_queue[$];
    list_reply_t replies_due[$];
    list_op_t    next_op;
    list_reply_t want;
    int          idle_left = 0;
    bit          no_idle = 1'b0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          gen_len = 0;

    bounded_ordered_list_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .value       (value),
        .position    (position),
        .done        (done),
        .status      (status),
        .found_index (found_index),
        .length      (length)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // works out the reply to one accepted transaction and updates the list
    function automatic void apply_list_op(input logic [ACT_W-1:0] act,
                                          input logic signed [DATA_W-1:0] val,
                                          input logic [POS_W-1:0] pos);
        list_reply_t r;
        r.status      = ST_OK;
        r.found_index = '0;
        case (act)
            ACT_FIND:
            begin
                r.status = ST_NOT_FOUND;
                // scan downward so the lowest match wins
                for (int i = list_len - 1; i >= 0; i--)
                begin
                    if (list_words[i] == val)
                    begin
                        r.status      = ST_OK;
                        r.found_index = i[FIDX_W-1:0];
                    end
                end
            end
            ACT_INSERT:
            begin
                if (int'(pos) > list_len)
                    r.status = ST_BAD_POSITION;
                else if (list_len >= LIST_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = list_len; i > int'(pos); i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = val;
                    list_len++;
                end
            end
            ACT_DELETE:
            begin
                if (int'(pos) >= list_len)
                    r.status = ST_BAD_POSITION;
                else
                begin
                    for (int i = int'(pos); i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            default:
                r.status = ST_BAD_POSITION;
        endcase
        r.length = list_len[LEN_W-1:0];
        replies_due.push_back(r);
    endfunction

    // queues one transaction and tracks the length the generator expects
    function automatic void add_op(input logic [ACT_W-1:0] act,
                                   input logic signed [DATA_W-1:0] val,
                                   input int pos);
        list_op_t op;
        op.act = act;
        op.val = val;
        op.pos = pos[POS_W-1:0];
        op_queue.push_back(op);
        if (act == ACT_INSERT && int'(op.pos) <= gen_len && gen_len < LIST_DEPTH)
            gen_len++;
        else if (act == ACT_DELETE && int'(op.pos) < gen_len)
            gen_len--;
    endfunction

    // small pool so finds hit and duplicates occur, plus extremes and full-width noise
    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            3: return 32'sd0;
            4, 5, 6: return $urandom_range(1, 6);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                apply_list_op(action, value, position);
                idle_left = no_idle ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 39) == 0)
                    no_idle = !no_idle;
            end
            // a held transaction stays on the ports until taken
            if (!(start && busy))
            begin
                if (idle_left == 0 && op_queue.size() != 0)
                begin
                    next_op = op_queue.pop_front();
                    start    <= 1'b1;
                    action   <= next_op.act;
                    value    <= next_op.val;
                    position <= next_op.pos;
                end
                else
                begin
                    start    <= 1'b0;
                    action   <= ACT_W'($urandom);
                    value    <= DATA_W'($urandom);
                    position <= POS_W'($urandom);
                    if (idle_left != 0)
                        idle_left--;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (replies_due.size() == 0)
            begin
                $error("result with no transaction pending: status %0d length %0d",
                       status, length);
                mismatch_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatch_count++;
                end
                if (found_index !== want.found_index)
                begin
                    $error("found_index: expected %0d, got %0d",
                           want.found_index, found_index);
                    mismatch_count++;
                end
                if (length !== want.length)
                begin
                    $error("length: expected %0d, got %0d", want.length, length);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int pick;
        int pos;
        logic [ACT_W-1:0] act;

        // directed: empty list corners
        add_op(ACT_FIND, 32'sd0, 0);
        add_op(ACT_DELETE, 32'sd0, 0);
        add_op(ACT_INSERT, 32'sd9, 1);
        add_op(ACT_UNUSED, -32'sd1, 0);
        // fill to the top with extremes, duplicates and varied positions
        add_op(ACT_INSERT, 32'sh8000_0000, 0);
        add_op(ACT_INSERT, 32'sh7fff_ffff, 1);
        add_op(ACT_INSERT, -32'sd1, 1);
        add_op(ACT_INSERT, 32'sd0, 0);
        add_op(ACT_INSERT, 32'sd5, 2);
        for (int k = 0; k < 11; k++)
            add_op(ACT_INSERT, (k % 3 == 0) ? 32'sd5 : k, (k % 2) ? gen_len : 0);
        // full list: valid position reports full, bad position wins over full
        add_op(ACT_INSERT, 32'sd77, 16);
        add_op(ACT_INSERT, 32'sd77, 31);
        add_op(ACT_FIND, 32'sd5, 0);
        add_op(ACT_FIND, 32'sd12345, 0);
        add_op(ACT_FIND, 32'sh8000_0000, 0);
        add_op(ACT_FIND, 32'sh7fff_ffff, 0);
        add_op(ACT_DELETE, 32'sd0, 16);
        add_op(ACT_DELETE, 32'sd0, 15);
        add_op(ACT_DELETE, 32'sd0, 0);

        // random: phases that grow, shrink or churn the list
        phase = 0;
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % 60 == 0)
                phase = $urandom_range(0, 2);
            pick = $urandom_range(0, 99);
            if (pick < 3)
                act = ACT_UNUSED;
            else if (phase == 0)
                act = (pick < 63) ? ACT_INSERT : (pick < 85) ? ACT_FIND : ACT_DELETE;
            else if (phase == 1)
                act = (pick < 58) ? ACT_DELETE : (pick < 80) ? ACT_FIND : ACT_INSERT;
            else
                act = (pick < 38) ? ACT_INSERT : (pick < 70) ? ACT_FIND : ACT_DELETE;

            if ($urandom_range(0, 9) == 0 || act == ACT_FIND || act == ACT_UNUSED)
                pos = $urandom_range(0, 31);
            else if (act == ACT_INSERT)
                pos = $urandom_range(0, gen_len);
            else
                pos = (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1);

            add_op(act, (act == ACT_DELETE) ? $urandom : pick_word(), pos);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() != 0 || start || replies_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && replies_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
